[design/tlvd_pkg.sv]
// Shared types and constants of the TLV stream deframer.
package tlvd_pkg;

   // Result word kinds
   localparam logic [1:0] KindHeader = 2'd0;
   localparam logic [1:0] KindValue  = 2'd1;
   localparam logic [1:0] KindError  = 2'd2;

   // Configuration register indexes
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = 8;
   localparam logic [CsrIndexWidth-1:0] CsrNetworkScope = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrEscapeCode   = 1'd1;
   localparam logic [CsrDataWidth-1:0]  EscapeCodeReset = 8'hFF;

   // Queue between front and back
   localparam int unsigned QDepth     = 4;
   localparam int unsigned QPtrWidth  = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int unsigned QCntWidth  = $clog2(QDepth + 1);

   typedef struct packed {
      logic [7:0] byte_in;
      logic       buffer_end;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tlv_type;
      logic [15:0] tlv_length;
      logic [7:0]  value_byte;
      logic [15:0] value_index;
      logic        tlv_done;
      logic        run_last;
   } rsp_word_type;

   // One queued entry: a first word, and a flag for a trailing error word
   typedef struct packed {
      rsp_word_type word;
      logic         has_err;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic       network_scope;
      logic [7:0] escape_code;
   } cfg_type;

endpackage

[design/tlv_stream_deframer_top.sv]
// Top level of the TLV stream deframer: configuration registers and part wiring.
//
// The deframer takes buffer bytes in and splits each buffer into
// type-length-value records, with an escape-coded 16-bit big-endian length.
// Each byte leaves zero, one or two result words: a header word, a value word
// with its index, and an error word when the buffer ends inside a record
// (downstream drops that record's words). A new byte is accepted every cycle
// unless the queue is full; the output register carries one word per cycle
// while rsp_stall is low, and a four-entry queue between the decoder and the
// output absorbs the bursts of bytes that cause two words before req_stall
// rises. A word passes from the decoder through the queue into the output
// register. The user must write configuration through the csr_ port only
// while the block is idle; the block itself does not enforce it.
module tlv_stream_deframer_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  tlvd_pkg::req_word_type                req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output tlvd_pkg::rsp_word_type                rsp_word,
   input  logic                                  csr_write,
   input  logic [tlvd_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [tlvd_pkg::CsrDataWidth-1:0]     csr_wdata
);

   logic                   scope_ff;
   logic [7:0]             escape_ff;
   tlvd_pkg::cfg_type      cfg;
   tlvd_pkg::q_push_type   q_push;
   tlvd_pkg::q_status_type q_status;
   tlvd_pkg::entry_type    pop_entry;
   logic                   pop;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scope_ff  <= 1'b0;
         escape_ff <= tlvd_pkg::EscapeCodeReset;
      end else if (csr_write) begin
         unique case (csr_index)
            tlvd_pkg::CsrNetworkScope: scope_ff  <= csr_wdata[0];
            tlvd_pkg::CsrEscapeCode:   escape_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.network_scope = scope_ff;
   assign cfg.escape_code   = escape_ff;

   tlvd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_word  (req_word),
      .q_status  (q_status),
      .req_stall (req_stall),
      .q_push    (q_push)
   );

   tlvd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .q_push    (q_push),
      .pop       (pop),
      .pop_entry (pop_entry),
      .q_status  (q_status)
   );

   tlvd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_entry (pop_entry),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

[design/tlvd_front.sv]
// Front part: accepts input words, tracks the TLV header and value phases.
module tlvd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  tlvd_pkg::cfg_type     cfg,
   input  logic                  req_valid,
   input  tlvd_pkg::req_word_type req_word,
   input  tlvd_pkg::q_status_type q_status,
   output logic                  req_stall,
   output tlvd_pkg::q_push_type  q_push
);

   localparam logic [2:0] PhIdle  = 3'd0;
   localparam logic [2:0] PhLen   = 3'd1;
   localparam logic [2:0] PhExtHi = 3'd2;
   localparam logic [2:0] PhExtLo = 3'd3;
   localparam logic [2:0] PhValue = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] taken_ff, taken_in;

   logic        accept;
   logic        hdr_now;
   logic [15:0] hdr_len;
   logic [15:0] next_idx;
   logic [7:0]  b;
   logic        last_byte;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign b         = req_word.byte_in;
   assign last_byte = req_word.buffer_end;
   assign next_idx  = taken_ff + 16'd1;

   // Decode the accepted word against the current phase
   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      taken_in = taken_ff;
      hdr_now  = 1'b0;
      hdr_len  = '0;
      q_push   = '0;

      if (accept) begin
         unique case (phase_ff)
            PhLen: begin
               if (b == cfg.escape_code) begin
                  len_in   = '0;
                  phase_in = PhExtHi;
                  if (last_byte) begin
                     q_push.valid                  = 1'b1;
                     q_push.entry.word.kind        = tlvd_pkg::KindError;
                     q_push.entry.word.tlv_type    = type_ff;
                     q_push.entry.word.run_last    = 1'b1;
                     phase_in = PhIdle;
                     taken_in = '0;
                  end
               end else begin
                  hdr_now = 1'b1;
                  hdr_len = {8'd0, b};
               end
            end
            PhExtHi: begin
               len_in   = {b, 8'd0};
               phase_in = PhExtLo;
               if (last_byte) begin
                  len_in   = '0;
                  taken_in = '0;
                  phase_in = PhIdle;
                  q_push.valid               = 1'b1;
                  q_push.entry.word.kind     = tlvd_pkg::KindError;
                  q_push.entry.word.tlv_type = type_ff;
                  q_push.entry.word.run_last = 1'b1;
               end
            end
            PhExtLo: begin
               hdr_now = 1'b1;
               hdr_len = {len_ff[15:8], b};
            end
            PhValue: begin
               q_push.valid                  = 1'b1;
               q_push.entry.word.kind        = tlvd_pkg::KindValue;
               q_push.entry.word.tlv_type    = type_ff;
               q_push.entry.word.tlv_length  = len_ff;
               q_push.entry.word.value_byte  = b;
               q_push.entry.word.value_index = taken_ff;
               if (next_idx == len_ff) begin
                  q_push.entry.word.tlv_done = 1'b1;
                  q_push.entry.word.run_last = 1'b1;
                  phase_in = PhIdle;
                  taken_in = '0;
               end else if (last_byte) begin
                  q_push.entry.has_err = 1'b1;
                  phase_in = PhIdle;
                  len_in   = '0;
                  taken_in = '0;
               end else begin
                  q_push.entry.word.run_last = 1'b1;
                  taken_in = next_idx;
               end
            end
            default: begin
               // Idle: take the type byte
               type_in  = cfg.network_scope ? {1'b0, b[7:1]} : b;
               len_in   = '0;
               taken_in = '0;
               phase_in = PhLen;
               if (last_byte) begin
                  q_push.valid               = 1'b1;
                  q_push.entry.word.kind     = tlvd_pkg::KindError;
                  q_push.entry.word.tlv_type = type_in;
                  q_push.entry.word.run_last = 1'b1;
                  phase_in = PhIdle;
               end
            end
         endcase

         // Header complete: emit it, then enter the value phase or finish (with a trailing error if the buffer ends)
         if (hdr_now) begin
            len_in   = hdr_len;
            taken_in = '0;
            q_push.valid                 = 1'b1;
            q_push.entry.word.kind       = tlvd_pkg::KindHeader;
            q_push.entry.word.tlv_type   = type_ff;
            q_push.entry.word.tlv_length = hdr_len;
            if (hdr_len == 16'd0) begin
               q_push.entry.word.tlv_done = 1'b1;
               q_push.entry.word.run_last = 1'b1;
               phase_in = PhIdle;
            end else if (last_byte) begin
               q_push.entry.has_err = 1'b1;
               phase_in = PhIdle;
               len_in   = '0;
            end else begin
               q_push.entry.word.run_last = 1'b1;
               phase_in = PhValue;
            end
         end
      end
   end

   // Hold the parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhIdle;
         type_ff  <= '0;
         len_ff   <= '0;
         taken_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         taken_ff <= taken_in;
      end
   end

endmodule

[design/tlvd_queue.sv]
// Short queue of decoded entries between the front and back parts.
module tlvd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  tlvd_pkg::q_push_type   q_push,
   input  logic                   pop,
   output tlvd_pkg::entry_type    pop_entry,
   output tlvd_pkg::q_status_type q_status
);

   tlvd_pkg::entry_type slot_ff [tlvd_pkg::QDepth];

   logic [tlvd_pkg::QPtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tlvd_pkg::QPtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tlvd_pkg::QCntWidth-1:0] count_ff, count_in;
   logic                           do_push, do_pop;

   localparam logic [tlvd_pkg::QPtrWidth-1:0] LastPtr =
      tlvd_pkg::QPtrWidth'(tlvd_pkg::QDepth - 1);
   localparam logic [tlvd_pkg::QCntWidth-1:0] FullCount =
      tlvd_pkg::QCntWidth'(tlvd_pkg::QDepth);

   assign q_status.full  = (count_ff == FullCount);
   assign q_status.empty = (count_ff == '0);
   assign do_push        = q_push.valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign pop_entry      = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

endmodule

[design/tlvd_back.sv]
// Back part: expands queued entries into result words on the output register.
module tlvd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  tlvd_pkg::entry_type    pop_entry,
   input  tlvd_pkg::q_status_type q_status,
   output logic                   pop,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output tlvd_pkg::rsp_word_type rsp_word
);

   logic                   valid_ff, valid_in;
   logic                   pend_err_ff, pend_err_in;
   tlvd_pkg::rsp_word_type word_ff, word_in;
   logic                   out_free;

   assign out_free  = !valid_ff || !rsp_stall;
   assign pop       = out_free && !pend_err_ff && !q_status.empty;
   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

   // Load the next word: a pending error first, then the queue head
   always_comb begin
      valid_in    = valid_ff;
      pend_err_in = pend_err_ff;
      word_in     = word_ff;
      if (out_free) begin
         if (pend_err_ff) begin
            valid_in            = 1'b1;
            pend_err_in         = 1'b0;
            word_in.kind        = tlvd_pkg::KindError;
            word_in.value_byte  = '0;
            word_in.value_index = '0;
            word_in.tlv_done    = 1'b0;
            word_in.run_last    = 1'b1;
         end else if (!q_status.empty) begin
            valid_in    = 1'b1;
            pend_err_in = pop_entry.has_err;
            word_in     = pop_entry.word;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         pend_err_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         pend_err_ff <= pend_err_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

[design/tlvd_checker.sv]
// Port-level checks of the TLV stream deframer and their binding.
module tlvd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input tlvd_pkg::rsp_word_type rsp_word
);

   // Only the three kinds appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.kind == tlvd_pkg::KindHeader ||
                     rsp_word.kind == tlvd_pkg::KindValue ||
                     rsp_word.kind == tlvd_pkg::KindError))
      else $error("unknown result kind");

   // An error closes the byte's words and never completes a record
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.kind == tlvd_pkg::KindError) |->
         (rsp_word.run_last && !rsp_word.tlv_done))
      else $error("malformed error word");

   // The final value byte sits at the last index of the record
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.kind == tlvd_pkg::KindValue && rsp_word.tlv_done) |->
         (rsp_word.value_index == rsp_word.tlv_length - 16'd1))
      else $error("record end at wrong index");

   // A header done mark only on an empty record
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.kind == tlvd_pkg::KindHeader && rsp_word.tlv_done) |->
         (rsp_word.tlv_length == 16'd0))
      else $error("header done on a non-empty record");

   // A stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result word changed");

endmodule

bind tlv_stream_deframer_top tlvd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
